// ===== hdl/simbe_pkg.sv =====
// Shared types and constants for the signed integer minimal byte encoder.
package simbe_pkg;

  localparam int unsigned CmdWidth   = 8;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NumBytes   = ValueWidth / ByteWidth;
  localparam int unsigned MaxDrop    = NumBytes - 1;
  localparam int unsigned WindowBits = ByteWidth + 1;
  localparam int unsigned DropWidth  = $clog2(NumBytes);
  localparam int unsigned CountWidth = $clog2(NumBytes + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  typedef logic [DropWidth-1:0]  drop_t;
  typedef logic [CountWidth-1:0] count_t;

  // One classified item: command, value with sign bytes shifted out, value byte count.
  typedef struct packed {
    logic [CmdWidth-1:0]   command;
    logic [ValueWidth-1:0] aligned;
    count_t                count;
  } entry_t;

endpackage

// ===== hdl/simbe_if.sv =====
// Valid/ready channel interfaces for input items and output frame bytes.
interface simbe_in_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  command;
  logic signed [63:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface simbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/signed_int_min_byte_encoder_core.sv =====
// Top level of the signed integer minimal-length byte encoder.
//
// Channels: items (sink) carries a command byte and a signed 64-bit value;
// frames (source) carries one byte per transfer with last on the final one.
// Each item becomes a frame: the command byte, then the value bytes left
// after redundant sign bytes are dropped, most significant first. Between
// one and eight value bytes follow, so a frame is 2 to 9 bytes long.
//
// An accepted item is written into the queue; its command byte is loaded
// into the output register once the serializer is free.
// Throughput: one output byte per cycle while the receiver is ready, frames
// back to back with no gap, set by the byte serializer. The front end
// classifies combinationally and keeps accepting into a two-entry queue
// while the serializer works.
//
// Reset (rst, synchronous, active high) empties the queue and the output
// register. When the receiver stalls, the output byte holds, the serializer
// waits, the queue fills, and then items.ready drops.
module signed_int_min_byte_encoder_core (
  input  logic        clk,
  input  logic        rst,
  simbe_in_if.sink    items,
  simbe_out_if.source frames
);
  import simbe_pkg::*;

  // front end -> queue
  logic   push_valid;
  logic   push_ready;
  entry_t push_data;

  // queue -> serializer
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  simbe_front u_front (
    .items      (items),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  simbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  simbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .frames    (frames)
  );

endmodule

// ===== hdl/simbe_front.sv =====
// Front end: accepts items, counts redundant sign bytes and left-aligns the value.
module simbe_front (
  simbe_in_if.sink         items,
  output logic             push_valid,
  output simbe_pkg::entry_t push_data,
  input  logic             push_ready
);
  import simbe_pkg::*;

  logic [MaxDrop-1:0] same;
  drop_t              drop;
  logic               run;
  logic [ValueWidth-1:0] val;

  assign val = items.value;

  // A byte is redundant when it and the top bit of the next byte all match.
  always_comb begin
    for (int j = 0; j < MaxDrop; j++) begin
      same[j] = (val[ValueWidth-1-ByteWidth*j -: WindowBits] == '0) ||
                (val[ValueWidth-1-ByteWidth*j -: WindowBits] == '1);
    end
  end

  always_comb begin
    drop = '0;
    run  = 1'b1;
    for (int j = 0; j < MaxDrop; j++) begin
      run = run & same[j];
      if (run) begin
        drop = DropWidth'(j + 1);
      end
    end
  end

  assign push_valid        = items.valid;
  assign items.ready       = push_ready;
  assign push_data.command = items.command;
  assign push_data.aligned = val << {drop, 3'b000};
  assign push_data.count   = CountWidth'(NumBytes) - CountWidth'(drop);

endmodule

// ===== hdl/simbe_queue.sv =====
// Two-entry queue decoupling classification from byte serialization.
module simbe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  simbe_pkg::entry_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output simbe_pkg::entry_t pop_data,
  input  logic              pop_ready
);
  import simbe_pkg::*;

  entry_t                mem [QueueDepth];
  logic [QPtrWidth-1:0]  wr_ptr;
  logic [QPtrWidth-1:0]  rd_ptr;
  logic [QCntWidth-1:0]  fill;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (fill != QCntWidth'(QueueDepth));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/simbe_back.sv =====
// Back end: serializes one queued entry into command byte plus value bytes.
module simbe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  simbe_pkg::entry_t pop_data,
  output logic              pop_ready,
  simbe_out_if.source       frames
);
  import simbe_pkg::*;

  logic                  active;
  logic [ValueWidth-1:0] shreg;
  count_t                remain;
  logic                  ovalid;
  logic [ByteWidth-1:0]  obyte;
  logic                  olast;
  logic                  can_load;

  assign can_load  = !ovalid || frames.ready;
  assign pop_ready = can_load && !active;

  assign frames.valid    = ovalid;
  assign frames.out_byte = obyte;
  assign frames.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else if (can_load) begin
      if (active) begin
        ovalid <= 1'b1;
        active <= (remain != count_t'(1));
      end else begin
        ovalid <= pop_valid;
        active <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (active) begin
        obyte  <= shreg[ValueWidth-1 -: ByteWidth];
        olast  <= (remain == count_t'(1));
        shreg  <= shreg << ByteWidth;
        remain <= remain - 1'b1;
      end else begin
        obyte  <= pop_data.command;
        olast  <= 1'b0;
        shreg  <= pop_data.aligned;
        remain <= pop_data.count;
      end
    end
  end

endmodule
